FILE: rtl/core/missing_two_by_cyclic_sort_assert.svh
// Assertion macros for the two-missing-number finder.
// Included by the modules that check their own control logic; needs clk and rst in scope.
`ifndef MISSING_TWO_BY_CYCLIC_SORT_ASSERT_SVH
`define MISSING_TWO_BY_CYCLIC_SORT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MTCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define MTCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MTCS_ASSERT(label, prop, msg)
`define MTCS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/core/mtcs_pkg.sv
// Shared constants, types and helpers of the two-missing-number finder.
// Used by the top level and mtcs_seq under rtl/core; depends on nothing.
package mtcs_pkg;

  localparam int MAX_TOTAL = 1024;
  localparam int ADDR_W    = $clog2(MAX_TOTAL);
  localparam int VAL_W     = 11;
  localparam int CODE_W    = 2;

  localparam logic [CODE_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [CODE_W-1:0] ERR_RANGE = 2'd1;
  localparam logic [CODE_W-1:0] ERR_DUP   = 2'd2;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  wdata;
  } mem_req_t;

  typedef struct packed {
    logic             done;
    logic             dup;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
  } seq_res_t;

  // The configured total clamped to the supported range.
  function automatic logic [VAL_W-1:0] eff_total(input logic [VAL_W-1:0] total);
    logic [VAL_W-1:0] n;
    n = total;
    if (total < VAL_W'(3)) begin
      n = VAL_W'(3);
    end else if (total > VAL_W'(MAX_TOTAL)) begin
      n = VAL_W'(MAX_TOTAL);
    end
    return n;
  endfunction

endpackage

FILE: rtl/core/missing_two_by_cyclic_sort.sv
// Top level of the two-missing-number finder: load path, configuration, result register.
// Depends on mtcs_pkg, mtcs_ram, mtcs_seq and the assertion macro header.
//
//   Channel  Signals                                    Direction
//   in       in_valid, in_ready, value                  beat in
//   out      out_valid, out_ready, missing_low/high,    beat out
//            error_code
//   cfg      cfg_we, cfg_wdata (total_count)            write only
//
// A value beat is stored as it is taken; the block is ready in every load cycle.
// After the last beat of a set the sort runs on the single store port: each slot visit
// reads the slot, each swap reads the target slot and writes both places, then the scan
// reads every slot and checks the two largest values, during which in_ready is low.
// Reset is synchronous; the store needs no clearing since each set writes every slot it reads.
// A result waiting on out_ready holds the sequencer in its final state.
`include "missing_two_by_cyclic_sort_assert.svh"
module missing_two_by_cyclic_sort (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mtcs_pkg::VAL_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mtcs_pkg::VAL_W-1:0]    value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mtcs_pkg::VAL_W-1:0]    missing_low,
  output logic [mtcs_pkg::VAL_W-1:0]    missing_high,
  output logic [mtcs_pkg::CODE_W-1:0]   error_code
);

  logic [mtcs_pkg::VAL_W-1:0]  total_count;
  logic [mtcs_pkg::VAL_W-1:0]  n;
  logic [mtcs_pkg::VAL_W-1:0]  set_size;
  logic [mtcs_pkg::VAL_W-1:0]  loaded_count;
  logic [mtcs_pkg::VAL_W-1:0]  loaded_count_next;
  logic                        range_err;
  logic                        accept;
  logic                        start;
  logic                        ack;
  logic                        seq_busy;
  mtcs_pkg::mem_req_t          seq_req;
  mtcs_pkg::mem_req_t          mem_req;
  mtcs_pkg::seq_res_t          seq_res;
  logic [mtcs_pkg::VAL_W-1:0]  rdata;
  logic [mtcs_pkg::CODE_W-1:0] code;

  assign n                 = mtcs_pkg::eff_total(total_count);
  assign set_size          = n - mtcs_pkg::VAL_W'(2);
  assign in_ready          = !seq_busy;
  assign accept            = in_valid && in_ready;
  assign loaded_count_next = loaded_count + mtcs_pkg::VAL_W'(1);
  assign start             = accept && (loaded_count_next >= set_size);
  assign ack               = seq_res.done && (!out_valid || out_ready);

  always_comb begin
    if (seq_busy) begin
      mem_req = seq_req;
    end else begin
      mem_req.we    = accept && (loaded_count < mtcs_pkg::VAL_W'(mtcs_pkg::MAX_TOTAL));
      mem_req.addr  = loaded_count[mtcs_pkg::ADDR_W-1:0];
      mem_req.wdata = value;
    end
  end

  always_comb begin
    if (range_err) begin
      code = mtcs_pkg::ERR_RANGE;
    end else if (seq_res.dup) begin
      code = mtcs_pkg::ERR_DUP;
    end else begin
      code = mtcs_pkg::ERR_NONE;
    end
  end

  mtcs_ram #(
    .DEPTH(mtcs_pkg::MAX_TOTAL),
    .WIDTH(mtcs_pkg::VAL_W)
  ) u_store (
    .clk  (clk),
    .we   (mem_req.we),
    .addr (mem_req.addr),
    .wdata(mem_req.wdata),
    .rdata(rdata)
  );

  mtcs_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .ack     (ack),
    .n       (n),
    .set_size(set_size),
    .rdata   (rdata),
    .mem_req (seq_req),
    .res     (seq_res),
    .busy    (seq_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      total_count  <= mtcs_pkg::VAL_W'(mtcs_pkg::MAX_TOTAL);
      loaded_count <= '0;
      range_err    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        total_count <= cfg_wdata;
      end
      if (accept) begin
        loaded_count <= loaded_count_next;
        if ((value == '0) || (value > n)) begin
          range_err <= 1'b1;
        end
      end
      if (ack) begin
        out_valid    <= 1'b1;
        error_code   <= code;
        missing_low  <= (code == mtcs_pkg::ERR_NONE) ? seq_res.lo : '0;
        missing_high <= (code == mtcs_pkg::ERR_NONE) ? seq_res.hi : '0;
        loaded_count <= '0;
        range_err    <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `MTCS_ASSERT_NEXT(a_last_starts, start, seq_busy, "sequencer did not start after the last beat")
  `MTCS_ASSERT(a_error_zeroes,
    !out_valid || (error_code == mtcs_pkg::ERR_NONE) ||
    ((missing_low == '0) && (missing_high == '0)),
    "error result carries values")
  `MTCS_ASSERT(a_ok_ordered,
    !out_valid || (error_code != mtcs_pkg::ERR_NONE) ||
    ((missing_low != '0) && (missing_low < missing_high)),
    "clean result out of order")

endmodule

FILE: rtl/core/mtcs_ram.sv
// Single-port value store with registered read data.
// Generic; no package dependency.
module mtcs_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/core/mtcs_seq.sv
// Sequencer for the in-place cyclic sort and the missing-slot scan over the value store.
// Depends on mtcs_pkg and the assertion macro header.
`include "missing_two_by_cyclic_sort_assert.svh"
module mtcs_seq (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     ack,
  input  logic [mtcs_pkg::VAL_W-1:0] n,
  input  logic [mtcs_pkg::VAL_W-1:0] set_size,
  input  logic [mtcs_pkg::VAL_W-1:0] rdata,
  output mtcs_pkg::mem_req_t       mem_req,
  output mtcs_pkg::seq_res_t       res,
  output logic                     busy
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SORT_RD  = 4'd1;
  localparam logic [3:0] S_SORT_CUR = 4'd2;
  localparam logic [3:0] S_SORT_CHK = 4'd3;
  localparam logic [3:0] S_SORT_TGT = 4'd4;
  localparam logic [3:0] S_SORT_SWB = 4'd5;
  localparam logic [3:0] S_SCAN_RD  = 4'd6;
  localparam logic [3:0] S_SCAN_CHK = 4'd7;
  localparam logic [3:0] S_TAIL_A   = 4'd8;
  localparam logic [3:0] S_TAIL_B   = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0]                   state;
  logic [mtcs_pkg::VAL_W-1:0]   idx;
  logic [mtcs_pkg::VAL_W-1:0]   cur;
  logic [mtcs_pkg::VAL_W-1:0]   tmp;
  logic                         dup;
  logic                         seen_a;
  logic                         seen_b;
  logic                         have_lo;
  logic                         have_hi;
  logic [mtcs_pkg::VAL_W-1:0]   lo;
  logic [mtcs_pkg::VAL_W-1:0]   hi;
  logic [mtcs_pkg::VAL_W-1:0]   idx_inc;
  logic [mtcs_pkg::VAL_W-1:0]   cur_dec;
  logic                         placeable;
  logic                         rec_en;
  logic [mtcs_pkg::VAL_W-1:0]   rec_val;

  assign idx_inc   = idx + mtcs_pkg::VAL_W'(1);
  assign cur_dec   = cur - mtcs_pkg::VAL_W'(1);
  assign placeable = (cur != '0) && (cur <= set_size) && (cur != idx_inc);

  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.addr  = idx[mtcs_pkg::ADDR_W-1:0];
    mem_req.wdata = cur;
    rec_en        = 1'b0;
    rec_val       = idx_inc;
    unique case (state)
      S_SORT_CHK: begin
        mem_req.addr = cur_dec[mtcs_pkg::ADDR_W-1:0];
      end
      S_SORT_TGT: begin
        mem_req.addr = cur_dec[mtcs_pkg::ADDR_W-1:0];
        mem_req.we   = (rdata != cur);
      end
      S_SORT_SWB: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = tmp;
      end
      S_SCAN_CHK: begin
        rec_en = (rdata != idx_inc);
      end
      S_TAIL_A: begin
        rec_en  = !seen_a;
        rec_val = n - mtcs_pkg::VAL_W'(1);
      end
      S_TAIL_B: begin
        rec_en  = !seen_b;
        rec_val = n;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      have_lo <= 1'b0;
      have_hi <= 1'b0;
      dup     <= 1'b0;
      seen_a  <= 1'b0;
      seen_b  <= 1'b0;
    end else begin
      if (rec_en) begin
        if (!have_lo) begin
          lo      <= rec_val;
          have_lo <= 1'b1;
        end else if (!have_hi) begin
          hi      <= rec_val;
          have_hi <= 1'b1;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            idx     <= '0;
            dup     <= 1'b0;
            seen_a  <= 1'b0;
            seen_b  <= 1'b0;
            have_lo <= 1'b0;
            have_hi <= 1'b0;
            lo      <= '0;
            hi      <= '0;
            state   <= S_SORT_RD;
          end
        end
        S_SORT_RD: begin
          if (idx >= set_size) begin
            idx   <= '0;
            state <= S_SCAN_RD;
          end else begin
            state <= S_SORT_CUR;
          end
        end
        S_SORT_CUR: begin
          cur   <= rdata;
          state <= S_SORT_CHK;
        end
        S_SORT_CHK: begin
          if (placeable) begin
            state <= S_SORT_TGT;
          end else begin
            idx   <= idx_inc;
            state <= S_SORT_RD;
          end
        end
        S_SORT_TGT: begin
          if (rdata == cur) begin
            dup   <= 1'b1;
            idx   <= idx_inc;
            state <= S_SORT_RD;
          end else begin
            tmp   <= rdata;
            state <= S_SORT_SWB;
          end
        end
        S_SORT_SWB: begin
          cur   <= tmp;
          state <= S_SORT_CHK;
        end
        S_SCAN_RD: begin
          if (idx >= set_size) begin
            state <= S_TAIL_A;
          end else begin
            state <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (rdata == n - mtcs_pkg::VAL_W'(1)) begin
            if (seen_a) begin
              dup <= 1'b1;
            end
            seen_a <= 1'b1;
          end
          if (rdata == n) begin
            if (seen_b) begin
              dup <= 1'b1;
            end
            seen_b <= 1'b1;
          end
          idx   <= idx_inc;
          state <= S_SCAN_RD;
        end
        S_TAIL_A: begin
          state <= S_TAIL_B;
        end
        S_TAIL_B: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (ack) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy     = (state != S_IDLE);
  assign res.done = (state == S_DONE);
  assign res.dup  = dup;
  assign res.lo   = lo;
  assign res.hi   = hi;

  `MTCS_ASSERT(a_hi_after_lo, !have_hi || (have_lo && (lo < hi)), "missing values out of order")
  `MTCS_ASSERT(a_write_only_swap, !mem_req.we || (state == S_SORT_TGT) || (state == S_SORT_SWB), "store written outside a swap")
  `MTCS_ASSERT(a_swap_nonzero, (state != S_SORT_TGT) || (cur != '0), "zero value taken for placement")

endmodule

FILE: verif/missing_pair_checker.sv
// Checker for the two-missing-number finder: watches the configuration, value and result
// channels, predicts each result and compares it. Depends on mtcs_pkg.
`timescale 1ns / 1ps
module missing_pair_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [mtcs_pkg::VAL_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [mtcs_pkg::VAL_W-1:0]  value,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [mtcs_pkg::VAL_W-1:0]  missing_low,
  input  logic [mtcs_pkg::VAL_W-1:0]  missing_high,
  input  logic [mtcs_pkg::CODE_W-1:0] error_code,
  output int                          mismatch_count,
  output int                          awaiting
);

  typedef struct packed {
    logic [mtcs_pkg::VAL_W-1:0]  lo;
    logic [mtcs_pkg::VAL_W-1:0]  hi;
    logic [mtcs_pkg::CODE_W-1:0] code;
  } finding_t;

  logic [mtcs_pkg::VAL_W-1:0] total_reg;
  logic [mtcs_pkg::VAL_W-1:0] set_store [mtcs_pkg::MAX_TOTAL];
  logic [mtcs_pkg::VAL_W-1:0] loaded_total;
  logic [1:0]                 bad_flags;
  finding_t                   expected_findings [$];
  finding_t                   oldest;

  task automatic flag_mismatch(input string what, input logic [mtcs_pkg::VAL_W-1:0] got,
                               input logic [mtcs_pkg::VAL_W-1:0] want);
    mismatch_count++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic absorb_value(input logic [mtcs_pkg::VAL_W-1:0] v);
    int       n;
    int       set_size;
    int       i;
    int       x;
    bit       seen [0:mtcs_pkg::MAX_TOTAL];
    finding_t f;
    n = int'(total_reg);
    if (n < 3) n = 3;
    if (n > mtcs_pkg::MAX_TOTAL) n = mtcs_pkg::MAX_TOTAL;
    set_size = n - 2;
    if (v == '0 || int'(v) > n) bad_flags[0] = 1'b1;
    if (loaded_total < mtcs_pkg::VAL_W'(mtcs_pkg::MAX_TOTAL)) begin
      set_store[loaded_total[mtcs_pkg::ADDR_W-1:0]] = v;
    end
    loaded_total = loaded_total + mtcs_pkg::VAL_W'(1);
    if (int'(loaded_total) >= set_size) begin
      for (i = 0; i <= mtcs_pkg::MAX_TOTAL; i++) seen[i[mtcs_pkg::VAL_W-1:0]] = 1'b0;
      for (i = 0; i < set_size; i++) begin
        x = int'(set_store[i[mtcs_pkg::ADDR_W-1:0]]);
        if (x != 0 && x <= n) begin
          if (seen[x[mtcs_pkg::VAL_W-1:0]]) bad_flags[1] = 1'b1;
          seen[x[mtcs_pkg::VAL_W-1:0]] = 1'b1;
        end
      end
      f.lo = '0;
      f.hi = '0;
      if (bad_flags[0]) begin
        f.code = mtcs_pkg::ERR_RANGE;
      end else if (bad_flags[1]) begin
        f.code = mtcs_pkg::ERR_DUP;
      end else begin
        f.code = mtcs_pkg::ERR_NONE;
        for (i = 1; i <= n; i++) begin
          if (!seen[i[mtcs_pkg::VAL_W-1:0]]) begin
            if (f.lo == '0) begin
              f.lo = mtcs_pkg::VAL_W'(i);
            end else if (f.hi == '0) begin
              f.hi = mtcs_pkg::VAL_W'(i);
            end
          end
        end
      end
      expected_findings.push_back(f);
      loaded_total = '0;
      bad_flags = '0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      total_reg = mtcs_pkg::VAL_W'(mtcs_pkg::MAX_TOTAL);
      loaded_total = '0;
      bad_flags = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_findings.size() == 0) begin
          flag_mismatch("unexpected result beat", missing_low, '0);
        end else begin
          oldest = expected_findings.pop_front();
          if (missing_low !== oldest.lo) flag_mismatch("missing_low", missing_low, oldest.lo);
          if (missing_high !== oldest.hi) flag_mismatch("missing_high", missing_high, oldest.hi);
          if (error_code !== oldest.code) flag_mismatch("error_code", error_code, oldest.code);
        end
      end
      if (in_valid && in_ready) absorb_value(value);
      if (cfg_we) total_reg = cfg_wdata;
    end
    awaiting = expected_findings.size();
  end

endmodule

FILE: verif/testbench.sv
// Top of the testbench for the two-missing-number finder: clock, reset, stimulus and verdict.
// Depends on mtcs_pkg, the block missing_two_by_cyclic_sort and missing_pair_checker.
`timescale 1ns / 1ps
module testbench;

  typedef enum int {BATCH_CLEAN, BATCH_RANGE, BATCH_DUP, BATCH_BOTH, BATCH_NOISE} batch_kind_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_we;
  logic [mtcs_pkg::VAL_W-1:0]  cfg_wdata;
  logic                        in_valid;
  logic                        in_ready;
  logic [mtcs_pkg::VAL_W-1:0]  value;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [mtcs_pkg::VAL_W-1:0]  missing_low;
  logic [mtcs_pkg::VAL_W-1:0]  missing_high;
  logic [mtcs_pkg::CODE_W-1:0] error_code;
  int                          mismatch_count;
  int                          awaiting;
  int                          send_idle_pct = 0;
  int                          recv_idle_pct = 0;
  int                          beats_sent = 0;
  logic [mtcs_pkg::VAL_W-1:0]  batch [$];

  always #2 clk = ~clk;

  always @(negedge clk) out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);

  missing_two_by_cyclic_sort u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .missing_low  (missing_low),
    .missing_high (missing_high),
    .error_code   (error_code)
  );

  missing_pair_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .value          (value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .missing_low    (missing_low),
    .missing_high   (missing_high),
    .error_code     (error_code),
    .mismatch_count (mismatch_count),
    .awaiting       (awaiting)
  );

  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int effective_n(input int reg_val);
    if (reg_val < 3) return 3;
    if (reg_val > mtcs_pkg::MAX_TOTAL) return mtcs_pkg::MAX_TOTAL;
    return reg_val;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_value(input logic [mtcs_pkg::VAL_W-1:0] v);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_batch();
    foreach (batch[i]) send_value(batch[i]);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic set_total(input int reg_val);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= mtcs_pkg::VAL_W'(reg_val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic make_batch(input int n, input batch_kind_t kind);
    int                         miss_a;
    int                         miss_b;
    int                         size;
    int                         i;
    int                         j;
    logic [mtcs_pkg::VAL_W-1:0] tmp;
    batch.delete();
    size = n - 2;
    miss_a = $urandom_range(n, 1);
    miss_b = miss_a;
    while (miss_b == miss_a) miss_b = $urandom_range(n, 1);
    for (i = 1; i <= n; i++) begin
      if (i != miss_a && i != miss_b) batch.push_back(mtcs_pkg::VAL_W'(i));
    end
    for (i = size - 1; i > 0; i--) begin
      j = $urandom_range(i, 0);
      tmp = batch[i];
      batch[i] = batch[j];
      batch[j] = tmp;
    end
    if ((kind == BATCH_DUP || kind == BATCH_BOTH) && size >= 2) begin
      i = $urandom_range(size - 1, 0);
      j = i;
      while (j == i) j = $urandom_range(size - 1, 0);
      batch[j] = batch[i];
    end
    if (kind == BATCH_RANGE || kind == BATCH_BOTH || (kind == BATCH_DUP && size < 2)) begin
      i = $urandom_range(size - 1, 0);
      batch[i] = $urandom_range(1, 0) ? '0 : mtcs_pkg::VAL_W'($urandom_range(2047, n + 1));
    end
    if (kind == BATCH_NOISE) begin
      for (i = 0; i < size; i++) begin
        batch[i] = $urandom_range(1, 0) ? mtcs_pkg::VAL_W'($urandom_range(2047, 0))
                                        : mtcs_pkg::VAL_W'($urandom_range(n + 2, 0));
      end
    end
  endtask

  initial begin
    int          phase;
    int          phase_start;
    int          reg_val;
    int          pick;
    int          sets;
    int          k;
    batch_kind_t kind;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    value = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_total(0);
    send_value(11'd1);
    send_value(11'd3);
    set_total(2);
    send_value(11'd2);
    set_total(3);
    send_value(11'd0);
    set_total(5);
    batch = '{11'd1, 11'd2, 11'd3};
    send_batch();
    batch = '{11'd5, 11'd1, 11'd3};
    send_batch();
    batch = '{11'd2, 11'd2, 11'd1};
    send_batch();
    batch = '{11'd6, 11'd1, 11'd1};
    send_batch();
    batch = '{11'd2047, 11'd4, 11'd5};
    send_batch();
    // A set begun at the largest size is cut short by a smaller size.
    set_total(1024);
    send_value(11'd3);
    send_value(11'd1);
    set_total(4);
    send_value(11'd2);

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 48 : 0;
      recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 8 : 0;
      if (phase == 2) begin
        set_total(2047);
        make_batch(mtcs_pkg::MAX_TOTAL, BATCH_CLEAN);
        send_batch();
      end
      phase_start = beats_sent;
      while (beats_sent - phase_start < 170) begin
        pick = $urandom_range(99, 0);
        if (pick < 8) begin
          reg_val = $urandom_range(2, 0);
        end else if (pick < 14) begin
          reg_val = $urandom_range(80, 25);
        end else begin
          reg_val = $urandom_range(24, 3);
        end
        set_total(reg_val);
        sets = $urandom_range(5, 2);
        for (k = 0; k < sets; k++) begin
          pick = $urandom_range(99, 0);
          if (pick < 70) begin
            kind = BATCH_CLEAN;
          end else if (pick < 80) begin
            kind = BATCH_RANGE;
          end else if (pick < 90) begin
            kind = BATCH_DUP;
          end else if (pick < 95) begin
            kind = BATCH_BOTH;
          end else begin
            kind = BATCH_NOISE;
          end
          make_batch(effective_n(reg_val), kind);
          send_batch();
        end
      end
    end

    in_valid <= 1'b0;
    for (k = 0; k < 40000 && awaiting != 0; k++) @(negedge clk);
    repeat (64) @(negedge clk);
    if (mismatch_count == 0 && awaiting == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
